>>> hw/rtl/msm_pkg.sv
// Shared types, constants and codes for the mid/side matrix with gain ramp.
`timescale 1ns / 1ps
`default_nettype none
package msm_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int GAIN_FRAC_BITS = 20;
	localparam int GAIN_BITS      = GAIN_FRAC_BITS + 4;
	localparam int NOW_BITS       = 48;
	localparam int EXT_BITS       = NOW_BITS - GAIN_BITS;
	localparam int STEP_BITS      = NOW_BITS + 1;
	localparam int FRAME_BITS     = 16;
	localparam int CNT_BITS       = $clog2(NOW_BITS);
	localparam int OP_BITS        = SAMPLE_BITS + 1;
	localparam int PROD_BITS      = OP_BITS + GAIN_BITS + 1;
	localparam int ACC_BITS       = PROD_BITS + 1;
	localparam int RES_BITS       = ACC_BITS - GAIN_FRAC_BITS;
	localparam int ADDR_BITS      = 5;
	localparam int DATA_BITS      = 32;

	localparam logic [GAIN_BITS-1:0]  GAIN_RST   = GAIN_BITS'(1 << GAIN_FRAC_BITS);
	localparam logic [FRAME_BITS-1:0] FRAMES_RST = FRAME_BITS'(240);

	typedef enum logic [2:0] {
		REG_MODE,
		REG_SWAP,
		REG_MID_TARGET,
		REG_SIDE_TARGET,
		REG_RAMP_FRAMES
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX,
		ST_APPLY,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                  mode;
		logic                  swap;
		logic [GAIN_BITS-1:0]  mid_target;
		logic [GAIN_BITS-1:0]  side_target;
		logic [FRAME_BITS-1:0] ramp_frames;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic div_start;
		logic div_step;
		logic div_fix;
		logic apply;
		logic mul;
		logic fin;
	} dp_cmd_t;

	typedef struct packed {
		logic started;
		logic changed;
		logic div_last;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/mid_side_matrix_gain_ramp_unit.sv
// Top level of the mid/side stereo matrix with ramped gains.
`timescale 1ns / 1ps
`default_nettype none
// One stereo pair is taken per beat and gives one result beat. In encode mode
// (mode 0) the outputs are mid = (L+R)/2 * mid gain and side = (L-R)/2 * side
// gain, L and R swapped first when swap is set; in decode mode (mode 1) they
// are M*gm + S*gs and M*gm - S*gs, in reverse order when swap is set. Results
// are rounded to nearest and saturated to 24 bits. Gains are unsigned Q4.20;
// the first sample after reset takes the targets as they stand, and a later
// change of either target ramps both gains linearly over ramp_frames samples
// (0 counts as 1). A sample goes from acceptance through the update of the
// gains, the multiply and the round and saturate step, which waits while the
// output register is full. A sample that sees a changed target first goes
// through the 48-step restoring ramp divider, one quotient bit a cycle.
// The result sits in an output register, so a new pair is accepted while the
// last result still waits. Registers (APB, 32-bit): mode 0x00, swap 0x04,
// mid_target 0x08, side_target 0x0C, ramp_frames 0x10; write them only while
// the block is idle.
module mid_side_matrix_gain_ramp_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic        [msm_pkg::ADDR_BITS-1:0]   paddr,
	input  wire logic        [msm_pkg::DATA_BITS-1:0]   pwdata,
	output logic             [msm_pkg::DATA_BITS-1:0]   prdata,
	output logic                                        pready,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic signed [msm_pkg::SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [msm_pkg::SAMPLE_BITS-1:0] right_in,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed      [msm_pkg::SAMPLE_BITS-1:0] first_out,
	output logic signed      [msm_pkg::SAMPLE_BITS-1:0] second_out
);
	import msm_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	msm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	msm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.sts        (sts),
		.left_in    (left_in),
		.right_in   (right_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.first_out  (first_out),
		.second_out (second_out)
	);

	// one item in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again while an item is in flight");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.fin))
		else $error("result beat appeared without a finish step");

	a_fin_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!out_valid || out_ready))
		else $error("finish step would overwrite a waiting result");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.div_step, cmd.div_fix, cmd.apply, cmd.mul, cmd.fin}))
		else $error("more than one sequencer phase active");

endmodule
`default_nettype wire

>>> hw/rtl/msm_regs.sv
// APB register file holding mode, swap, gain targets and ramp length.
`timescale 1ns / 1ps
`default_nettype none
module msm_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [msm_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [msm_pkg::DATA_BITS-1:0] pwdata,
	output logic      [msm_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready,
	output msm_pkg::cfg_t                      cfg
);
	import msm_pkg::*;

	reg_idx_t idx;
	logic     wr_en;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= 1'b0;
			cfg_q.swap        <= 1'b0;
			cfg_q.mid_target  <= GAIN_RST;
			cfg_q.side_target <= GAIN_RST;
			cfg_q.ramp_frames <= FRAMES_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_MODE:        cfg_q.mode        <= pwdata[0];
				REG_SWAP:        cfg_q.swap        <= pwdata[0];
				REG_MID_TARGET:  cfg_q.mid_target  <= pwdata[GAIN_BITS-1:0];
				REG_SIDE_TARGET: cfg_q.side_target <= pwdata[GAIN_BITS-1:0];
				REG_RAMP_FRAMES: cfg_q.ramp_frames <= pwdata[FRAME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MODE:        prdata = DATA_BITS'(cfg_q.mode);
			REG_SWAP:        prdata = DATA_BITS'(cfg_q.swap);
			REG_MID_TARGET:  prdata = DATA_BITS'(cfg_q.mid_target);
			REG_SIDE_TARGET: prdata = DATA_BITS'(cfg_q.side_target);
			REG_RAMP_FRAMES: prdata = DATA_BITS'(cfg_q.ramp_frames);
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/msm_ctrl.sv
// Sequencer: accept, optional step division, gain update, multiply, output.
`timescale 1ns / 1ps
`default_nettype none
module msm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire msm_pkg::dp_sts_t sts,
	output msm_pkg::dp_cmd_t      cmd
);
	import msm_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (!sts.started) begin
						cmd.load  = 1'b1;
						state_nxt = ST_APPLY;
					end else if (sts.changed) begin
						cmd.div_start = 1'b1;
						state_nxt     = ST_DIV;
					end else begin
						state_nxt = ST_APPLY;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.div_fix = 1'b1;
				state_nxt   = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_nxt = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/msm_dp.sv
// Datapath: gain state, ramp step divider, matrix multiply, round and saturate.
`timescale 1ns / 1ps
`default_nettype none
module msm_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire msm_pkg::cfg_t                          cfg,
	input  wire msm_pkg::dp_cmd_t                       cmd,
	output msm_pkg::dp_sts_t                            sts,
	input  wire logic signed [msm_pkg::SAMPLE_BITS-1:0] left_in,
	input  wire logic signed [msm_pkg::SAMPLE_BITS-1:0] right_in,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed      [msm_pkg::SAMPLE_BITS-1:0] first_out,
	output logic signed      [msm_pkg::SAMPLE_BITS-1:0] second_out
);
	import msm_pkg::*;

	localparam logic [CNT_BITS-1:0]        DIV_LAST = CNT_BITS'(NOW_BITS - 1);
	localparam logic signed [ACC_BITS-1:0] RND_ENC  = ACC_BITS'(1 << GAIN_FRAC_BITS);
	localparam logic signed [ACC_BITS-1:0] RND_DEC  = ACC_BITS'(1 << (GAIN_FRAC_BITS - 1));
	localparam logic signed [RES_BITS-1:0] SAT_HI   = RES_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [RES_BITS-1:0] SAT_LO   = -SAT_HI - RES_BITS'(1);

	// one restoring division step: {remainder, quotient/dividend shift}
	function automatic logic [FRAME_BITS+NOW_BITS-1:0] div_step(
		input logic [FRAME_BITS-1:0] rem,
		input logic [NOW_BITS-1:0]   quo,
		input logic [FRAME_BITS-1:0] dvs
	);
		logic [FRAME_BITS:0] trial;
		logic [FRAME_BITS:0] diff;
		trial = {rem, quo[NOW_BITS-1]};
		diff  = trial - {1'b0, dvs};
		if (trial >= {1'b0, dvs}) begin
			return {diff[FRAME_BITS-1:0], quo[NOW_BITS-2:0], 1'b1};
		end
		return {trial[FRAME_BITS-1:0], quo[NOW_BITS-2:0], 1'b0};
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [RES_BITS-1:0] v);
		if (v > SAT_HI) begin
			return SAT_HI[SAMPLE_BITS-1:0];
		end
		if (v < SAT_LO) begin
			return SAT_LO[SAMPLE_BITS-1:0];
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	logic signed [SAMPLE_BITS-1:0] a_q, b_q;
	logic                          started_q;
	logic [NOW_BITS-1:0]           mid_now_q, side_now_q;
	logic signed [STEP_BITS-1:0]   mid_step_q, side_step_q;
	logic [GAIN_BITS-1:0]          mid_seen_q, side_seen_q;
	logic [FRAME_BITS-1:0]         ramp_left_q;
	logic [FRAME_BITS-1:0]         divisor_q;
	logic                          mid_neg_q, side_neg_q;
	logic [NOW_BITS-1:0]           mid_quo_q, side_quo_q;
	logic [FRAME_BITS-1:0]         mid_rem_q, side_rem_q;
	logic [CNT_BITS-1:0]           div_cnt_q;
	logic signed [PROD_BITS-1:0]   mid_prod_q, side_prod_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] first_q, second_q;

	logic [NOW_BITS-1:0]           mid_tgt_ext, side_tgt_ext;
	logic                          mid_up, side_up;
	logic [NOW_BITS-1:0]           mid_mag, side_mag;
	logic [FRAME_BITS-1:0]         frames;
	logic signed [OP_BITS-1:0]     sa, sb, lsel, rsel, op_m, op_s;
	logic signed [GAIN_BITS:0]     gm, gs;
	logic signed [ACC_BITS-1:0]    enc_m_acc, enc_s_acc, sum_acc, dif_acc;
	logic signed [RES_BITS-1:0]    enc_m, enc_s, dec_sum, dec_dif, r1, r2;

	assign mid_tgt_ext  = {cfg.mid_target, EXT_BITS'(0)};
	assign side_tgt_ext = {cfg.side_target, EXT_BITS'(0)};
	assign mid_up       = mid_tgt_ext >= mid_now_q;
	assign side_up      = side_tgt_ext >= side_now_q;
	assign mid_mag      = mid_up ? mid_tgt_ext - mid_now_q : mid_now_q - mid_tgt_ext;
	assign side_mag     = side_up ? side_tgt_ext - side_now_q : side_now_q - side_tgt_ext;
	assign frames       = (cfg.ramp_frames == '0) ? FRAME_BITS'(1) : cfg.ramp_frames;

	assign sts.started  = started_q;
	assign sts.changed  = (cfg.mid_target != mid_seen_q) || (cfg.side_target != side_seen_q);
	assign sts.div_last = div_cnt_q == DIV_LAST;
	assign sts.out_free = !out_valid_q || out_ready;

	// matrix operands
	assign sa   = OP_BITS'(a_q);
	assign sb   = OP_BITS'(b_q);
	assign lsel = cfg.swap ? sb : sa;
	assign rsel = cfg.swap ? sa : sb;
	assign op_m = cfg.mode ? sa : lsel + rsel;
	assign op_s = cfg.mode ? sb : lsel - rsel;
	assign gm   = {1'b0, mid_now_q[NOW_BITS-1 -: GAIN_BITS]};
	assign gs   = {1'b0, side_now_q[NOW_BITS-1 -: GAIN_BITS]};

	// round to nearest, ties up
	assign enc_m_acc = ACC_BITS'(mid_prod_q) + RND_ENC;
	assign enc_s_acc = ACC_BITS'(side_prod_q) + RND_ENC;
	assign sum_acc   = ACC_BITS'(mid_prod_q) + ACC_BITS'(side_prod_q) + RND_DEC;
	assign dif_acc   = ACC_BITS'(mid_prod_q) - ACC_BITS'(side_prod_q) + RND_DEC;
	assign enc_m     = RES_BITS'(enc_m_acc >>> (GAIN_FRAC_BITS + 1));
	assign enc_s     = RES_BITS'(enc_s_acc >>> (GAIN_FRAC_BITS + 1));
	assign dec_sum   = RES_BITS'(sum_acc >>> GAIN_FRAC_BITS);
	assign dec_dif   = RES_BITS'(dif_acc >>> GAIN_FRAC_BITS);
	assign r1        = cfg.mode ? (cfg.swap ? dec_dif : dec_sum) : enc_m;
	assign r2        = cfg.mode ? (cfg.swap ? dec_sum : dec_dif) : enc_s;

	assign out_valid  = out_valid_q;
	assign first_out  = first_q;
	assign second_out = second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			ramp_left_q <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				started_q   <= 1'b1;
				ramp_left_q <= '0;
			end
			if (cmd.div_start) begin
				ramp_left_q <= frames;
				div_cnt_q   <= '0;
			end
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + CNT_BITS'(1);
			end
			if (cmd.apply && ramp_left_q != '0) begin
				ramp_left_q <= ramp_left_q - FRAME_BITS'(1);
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_q <= left_in;
			b_q <= right_in;
		end
		if (cmd.load) begin
			mid_seen_q  <= cfg.mid_target;
			side_seen_q <= cfg.side_target;
			mid_now_q   <= mid_tgt_ext;
			side_now_q  <= side_tgt_ext;
		end
		if (cmd.div_start) begin
			mid_seen_q  <= cfg.mid_target;
			side_seen_q <= cfg.side_target;
			divisor_q   <= frames;
			mid_neg_q   <= !mid_up;
			side_neg_q  <= !side_up;
			mid_quo_q   <= mid_mag;
			side_quo_q  <= side_mag;
			mid_rem_q   <= '0;
			side_rem_q  <= '0;
		end
		if (cmd.div_step) begin
			{mid_rem_q, mid_quo_q}   <= div_step(mid_rem_q, mid_quo_q, divisor_q);
			{side_rem_q, side_quo_q} <= div_step(side_rem_q, side_quo_q, divisor_q);
		end
		if (cmd.div_fix) begin
			mid_step_q  <= mid_neg_q ? -$signed({1'b0, mid_quo_q}) : $signed({1'b0, mid_quo_q});
			side_step_q <= side_neg_q ? -$signed({1'b0, side_quo_q})
				: $signed({1'b0, side_quo_q});
		end
		if (cmd.apply && ramp_left_q != '0) begin
			// last sample of a ramp lands exactly on the target
			if (ramp_left_q == FRAME_BITS'(1)) begin
				mid_now_q  <= {mid_seen_q, EXT_BITS'(0)};
				side_now_q <= {side_seen_q, EXT_BITS'(0)};
			end else begin
				mid_now_q  <= mid_now_q + mid_step_q[NOW_BITS-1:0];
				side_now_q <= side_now_q + side_step_q[NOW_BITS-1:0];
			end
		end
		if (cmd.mul) begin
			mid_prod_q  <= op_m * gm;
			side_prod_q <= op_s * gs;
		end
		if (cmd.fin) begin
			first_q  <= sat(r1);
			second_q <= sat(r2);
		end
	end

endmodule
`default_nettype wire

>>> tb/sv/tb_mid_side_matrix_gain_ramp_unit.sv
// Self-checking testbench for the mid/side matrix gain ramp unit.
`timescale 1ns / 1ps
module tb_mid_side_matrix_gain_ramp_unit;
	import msm_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1_200_000;
	localparam int unsigned RANDOM_ITEMS = 1400;
	localparam int unsigned SHOWN_ERRORS = 10;
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;
	localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [GAIN_BITS-1:0]   GAIN_MAX = '1;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] first;
		logic [SAMPLE_BITS-1:0] second;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_BITS-1:0] left_in = '0;
	logic signed [SAMPLE_BITS-1:0] right_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] first_out;
	logic signed [SAMPLE_BITS-1:0] second_out;

	// predictor copy of the registers and the gain state
	cfg_t shadow = '{mode: MODE_ENCODE, swap: 1'b0, mid_target: GAIN_RST,
		side_target: GAIN_RST, ramp_frames: FRAMES_RST};
	logic [NOW_BITS-1:0]  mid_now = '0;
	logic [NOW_BITS-1:0]  side_now = '0;
	longint               mid_step = 0;
	longint               side_step = 0;
	logic [GAIN_BITS-1:0] mid_seen = '0;
	logic [GAIN_BITS-1:0] side_seen = '0;
	int unsigned          frames_left = 0;
	bit                   gains_live = 1'b0;

	pair_t       pending_pairs[$];
	int unsigned beats_in = 0;
	int unsigned beats_out = 0;
	int unsigned mismatches = 0;
	int unsigned reg_writes = 0;
	int unsigned phases = 0;
	bit          gaps_on = 1'b0;
	bit          stalls_on = 1'b0;
	int unsigned stall_left = 0;

	mid_side_matrix_gain_ramp_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.left_in    (left_in),
		.right_in   (right_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.first_out  (first_out),
		.second_out (second_out)
	);

	always #5 clk = ~clk;

	function automatic longint round_near(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] clip(longint v);
		longint hi;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		if (v > hi) return S_MAX;
		if (v < -hi - 1) return S_MIN;
		return v[SAMPLE_BITS-1:0];
	endfunction

	function automatic pair_t mix_sample(logic signed [SAMPLE_BITS-1:0] l_s,
			logic signed [SAMPLE_BITS-1:0] r_s);
		longint a, b, gm, gs, frames, x, y, mo, so, r1, r2;
		pair_t res;
		a = l_s;
		b = r_s;
		if (!gains_live) begin
			mid_seen = shadow.mid_target;
			side_seen = shadow.side_target;
			mid_now = {shadow.mid_target, {EXT_BITS{1'b0}}};
			side_now = {shadow.side_target, {EXT_BITS{1'b0}}};
			mid_step = 0;
			side_step = 0;
			frames_left = 0;
			gains_live = 1'b1;
		end else if (shadow.mid_target != mid_seen || shadow.side_target != side_seen) begin
			frames = (shadow.ramp_frames == '0) ? 1 : longint'(shadow.ramp_frames);
			mid_seen = shadow.mid_target;
			side_seen = shadow.side_target;
			mid_step = (longint'({mid_seen, {EXT_BITS{1'b0}}}) - longint'(mid_now)) / frames;
			side_step = (longint'({side_seen, {EXT_BITS{1'b0}}}) - longint'(side_now)) / frames;
			frames_left = 32'(frames);
		end
		if (frames_left != 0) begin
			mid_now = NOW_BITS'(longint'(mid_now) + mid_step);
			side_now = NOW_BITS'(longint'(side_now) + side_step);
			frames_left--;
			if (frames_left == 0) begin
				mid_now = {mid_seen, {EXT_BITS{1'b0}}};
				side_now = {side_seen, {EXT_BITS{1'b0}}};
			end
		end
		gm = longint'(mid_now[NOW_BITS-1 -: GAIN_BITS]);
		gs = longint'(side_now[NOW_BITS-1 -: GAIN_BITS]);
		if (shadow.mode == MODE_ENCODE) begin
			x = shadow.swap ? b : a;
			y = shadow.swap ? a : b;
			r1 = round_near((x + y) * gm, GAIN_FRAC_BITS + 1);
			r2 = round_near((x - y) * gs, GAIN_FRAC_BITS + 1);
		end else begin
			mo = a * gm;
			so = b * gs;
			x = round_near(mo + so, GAIN_FRAC_BITS);
			y = round_near(mo - so, GAIN_FRAC_BITS);
			r1 = shadow.swap ? y : x;
			r2 = shadow.swap ? x : y;
		end
		res.first = clip(r1);
		res.second = clip(r2);
		return res;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		logic [SAMPLE_BITS-1:0] s;
		s = SAMPLE_BITS'($urandom);
		case ($urandom_range(0, 15))
			0: s = S_MAX;
			1: s = S_MIN;
			2: s = '0;
			3: s = '1;
			default: ;
		endcase
		return s;
	endfunction

	function automatic logic [GAIN_BITS-1:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return GAIN_MAX;
			2: return GAIN_RST;
			default: return GAIN_BITS'($urandom_range(0, 24'h3FFFFF));
		endcase
	endfunction

	function automatic logic [FRAME_BITS-1:0] pick_frames();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			2: return FRAME_BITS'(1);
			3, 4, 5: return FRAME_BITS'($urandom_range(33, 400));
			default: return FRAME_BITS'($urandom_range(2, 32));
		endcase
	endfunction

	// result check and prediction on accepted beats
	always @(posedge clk) begin : monitor
		pair_t want;
		if (out_valid && out_ready) begin
			beats_out++;
			if (pending_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("result beat %0d with none expected: first %0d second %0d",
						beats_out, first_out, second_out);
			end else begin
				want = pending_pairs.pop_front();
				if (want != {first_out, second_out}) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("beat %0d: expected first %0d second %0d, got %0d %0d",
							beats_out, $signed(want.first), $signed(want.second),
							first_out, second_out);
				end
			end
		end
		if (in_valid && in_ready) begin
			beats_in++;
			pending_pairs.push_back(mix_sample(left_in, right_in));
		end
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else begin
			stall_left = stalls_on ? pick_gap() : 0;
			out_ready = (stall_left == 0);
			if (stall_left != 0) stall_left--;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	task automatic send_pair(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r);
		int unsigned gap, seen;
		gap = gaps_on ? pick_gap() : 0;
		repeat (gap) @(negedge clk);
		left_in = l;
		right_in = r;
		in_valid = 1'b1;
		seen = beats_in;
		do @(negedge clk); while (beats_in == seen);
		in_valid = 1'b0;
	endtask

	task automatic await_idle();
		while (pending_pairs.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [DATA_BITS-1:0] v);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_MODE:        shadow.mode = v[0];
			REG_SWAP:        shadow.swap = v[0];
			REG_MID_TARGET:  shadow.mid_target = v[GAIN_BITS-1:0];
			REG_SIDE_TARGET: shadow.side_target = v[GAIN_BITS-1:0];
			REG_RAMP_FRAMES: shadow.ramp_frames = v[FRAME_BITS-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// reset settings; first beat loads unity gains, odd sums hit the rounding tie
	task automatic test_default_encode();
		send_pair('0, '0);
		send_pair(SAMPLE_BITS'(1), '0);
		send_pair('1, '0);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, S_MIN);
		send_pair(S_MAX, S_MIN);
		send_pair(S_MIN, S_MAX);
		await_idle();
	endtask

	task automatic test_decode_and_swap();
		reg_write(REG_RAMP_FRAMES, DATA_BITS'(1));
		reg_write(REG_MODE, DATA_BITS'(MODE_DECODE));
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, S_MAX);
		send_pair(S_MIN, S_MIN);
		await_idle();
		reg_write(REG_SWAP, DATA_BITS'(1));
		send_pair(S_MAX, SAMPLE_BITS'(1));
		send_pair(SAMPLE_BITS'(5), SAMPLE_BITS'(-3));
		await_idle();
		reg_write(REG_MODE, DATA_BITS'(MODE_ENCODE));
		send_pair(SAMPLE_BITS'(100), SAMPLE_BITS'(-7));
		send_pair(S_MAX, S_MIN);
		await_idle();
		// zero ramp length acts as one, full-scale and zero gains
		reg_write(REG_RAMP_FRAMES, '0);
		reg_write(REG_MID_TARGET, DATA_BITS'(GAIN_MAX));
		reg_write(REG_SIDE_TARGET, '0);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, S_MAX);
		await_idle();
	endtask

	// ramp, restart mid-ramp, then a ramp length change that must not restart it
	task automatic test_ramp_restart();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		reg_write(REG_SWAP, '0);
		reg_write(REG_RAMP_FRAMES, DATA_BITS'(6));
		reg_write(REG_MID_TARGET, DATA_BITS'(24'h080000));
		reg_write(REG_SIDE_TARGET, DATA_BITS'(24'h200000));
		repeat (3) send_pair(pick_sample(), pick_sample());
		await_idle();
		reg_write(REG_MID_TARGET, DATA_BITS'(24'h300000));
		repeat (3) send_pair(pick_sample(), pick_sample());
		await_idle();
		reg_write(REG_RAMP_FRAMES, DATA_BITS'(16'hFFFF));
		repeat (3) send_pair(pick_sample(), pick_sample());
		await_idle();
	endtask

	task automatic test_random_traffic();
		int unsigned n, done;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			await_idle();
			if ($urandom_range(0, 1)) reg_write(REG_MODE, DATA_BITS'($urandom_range(0, 1)));
			if ($urandom_range(0, 1)) reg_write(REG_SWAP, DATA_BITS'($urandom_range(0, 1)));
			if ($urandom_range(0, 2) != 0) reg_write(REG_MID_TARGET, DATA_BITS'(pick_gain()));
			if ($urandom_range(0, 2) != 0) reg_write(REG_SIDE_TARGET, DATA_BITS'(pick_gain()));
			if ($urandom_range(0, 2) == 0) reg_write(REG_RAMP_FRAMES, DATA_BITS'(pick_frames()));
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			n = $urandom_range(10, 80);
			repeat (n) send_pair(pick_sample(), pick_sample());
			done += n;
			phases++;
		end
		await_idle();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_default_encode();
		test_decode_and_swap();
		test_ramp_restart();
		test_random_traffic();
		repeat (60) @(negedge clk);
		$display("%0d sample pairs sent, %0d result beats checked, %0d mismatches",
			beats_in, beats_out, mismatches);
		$display("encode and decode, swap, gain jumps and ramps over %0d random phases, %0d writes",
			phases, reg_writes);
		if (mismatches == 0 && pending_pairs.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/msm_pkg.sv
hw/rtl/msm_regs.sv
hw/rtl/msm_ctrl.sv
hw/rtl/msm_dp.sv
hw/rtl/mid_side_matrix_gain_ramp_unit.sv
tb/sv/tb_mid_side_matrix_gain_ramp_unit.sv
